// ===== hdl/iafp_pkg.sv =====
// Package: widths, pipeline types and arctangent table for the far-point angle block.
`default_nettype none
package iafp_pkg;

  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_W         = 16;
  localparam int ACC_FRAC        = 24;
  localparam int CORDIC_STEPS    = 24;
  localparam int NORM_EXP        = 40;

  // Difference, product, cross/dot, CORDIC lane and angle accumulator widths
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int CDW = PW + 1;
  localparam int XW  = NORM_EXP + 5;
  localparam int ZW  = ACC_FRAC + 10;
  localparam int SHW = $clog2(NORM_EXP + 1);

  // Register stages: front 4, normalize 2, CORDIC, output 1
  localparam int FRONT_ST = 4;
  localparam int NORM_ST  = 2;
  localparam int NSTAGES  = FRONT_ST + NORM_ST + CORDIC_STEPS + 1;

  localparam logic signed [ZW-1:0] Z_90  = ZW'(90) <<< ACC_FRAC;
  localparam logic signed [ZW-1:0] Z_180 = ZW'(180) <<< ACC_FRAC;
  localparam int ANGLE_MAX = 180 << ANGLE_FRAC_BITS;

  typedef struct packed {
    logic signed [CDW-1:0] crs;
    logic signed [CDW-1:0] dot;
    logic                  degen;
  } cd_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 bypass;
    logic                 degen;
  } lane_t;

  // round(atan(2^-i) * 180 / pi * 2^24)
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    case (i)
      0:  return ZW'(754974720);
      1:  return ZW'(445687602);
      2:  return ZW'(235489088);
      3:  return ZW'(119537938);
      4:  return ZW'(60000934);
      5:  return ZW'(30029717);
      6:  return ZW'(15018523);
      7:  return ZW'(7509720);
      8:  return ZW'(3754917);
      9:  return ZW'(1877466);
      10: return ZW'(938734);
      11: return ZW'(469367);
      12: return ZW'(234684);
      13: return ZW'(117342);
      14: return ZW'(58671);
      15: return ZW'(29335);
      16: return ZW'(14668);
      17: return ZW'(7334);
      18: return ZW'(3667);
      19: return ZW'(1833);
      20: return ZW'(917);
      21: return ZW'(458);
      22: return ZW'(229);
      23: return ZW'(115);
      default: return '0;
    endcase
  endfunction

  // Right shift that truncates the magnitude toward zero
  function automatic logic signed [XW-1:0] shr0(input logic signed [XW-1:0] v, input int s);
    logic signed [XW-1:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> s;
    return (v < 0) ? -m : m;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/inner_angle_at_far_point_top.sv =====
// Top level: angle at the far vertex of a point triple, fully pipelined.
// Usage:
//   Input beat: two candidate points and a reference point C, 12-bit pixel
//   coordinates. The candidate strictly closer to C is B, the other is the
//   vertex A (first candidate on a tie). Output beat: angle at A between
//   A->B and A->C in degrees, unsigned Q8.8 in 0..180, plus a degenerate
//   flag (angle 0) when either vector has zero length.
// Throughput: one beat per cycle while the output is not stalled. Pipeline:
//   31 register stages: 4 front arithmetic stages, 2 normalize stages, one
//   stage per CORDIC iteration (24) and the output register.
// Stalls: each stage holds its beat while the next one is full and held, so bubbles
//   close up and a stalled output holds its payload; in_ready drops only
//   once every stage is occupied. Nothing is lost or repeated.
// Reset: synchronous, active low; clears all stage valid bits, so the
//   pipeline comes up empty and in_ready is high.
`default_nettype none
module inner_angle_at_far_point_top
  import iafp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] in_first_x,
  input  wire logic [COORD_BITS-1:0] in_first_y,
  input  wire logic [COORD_BITS-1:0] in_second_x,
  input  wire logic [COORD_BITS-1:0] in_second_y,
  input  wire logic [COORD_BITS-1:0] in_ref_x,
  input  wire logic [COORD_BITS-1:0] in_ref_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ANGLE_W-1:0]         out_angle_deg,
  output logic                       out_degenerate
);

  localparam int CS = FRONT_ST + NORM_ST;

  logic [NSTAGES-1:0] v_r, v_nxt;
  logic [NSTAGES:0]   en;
  cd_t   cd;
  lane_t lane_n, lane_c;

  // Per-stage enable: a stage loads when empty or when its successor moves
  always_comb begin
    en[NSTAGES] = out_ready;
    for (int k = NSTAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < NSTAGES; k++) begin
      if (en[k]) v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      else       v_nxt[k] = v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  iafp_front u_front (
    .clk      (clk),
    .en       (en[FRONT_ST-1:0]),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .ref_x    (in_ref_x),
    .ref_y    (in_ref_y),
    .cd       (cd)
  );

  iafp_norm u_norm (
    .clk  (clk),
    .en   (en[CS-1:FRONT_ST]),
    .cd   (cd),
    .lane (lane_n)
  );

  iafp_cordic u_cordic (
    .clk      (clk),
    .en       (en[CS+CORDIC_STEPS-1:CS]),
    .lane_in  (lane_n),
    .lane_out (lane_c)
  );

  iafp_out u_out (
    .clk        (clk),
    .en         (en[NSTAGES-1]),
    .lane       (lane_c),
    .angle_deg  (out_angle_deg),
    .degenerate (out_degenerate)
  );

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTAGES-1];

endmodule
`default_nettype wire

// ===== hdl/iafp_front.sv =====
// Front stages: distances, vertex choice, difference vectors, cross and dot products.
`default_nettype none
module iafp_front
  import iafp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [FRONT_ST-1:0]   en,
  input  wire logic [COORD_BITS-1:0] first_x,
  input  wire logic [COORD_BITS-1:0] first_y,
  input  wire logic [COORD_BITS-1:0] second_x,
  input  wire logic [COORD_BITS-1:0] second_y,
  input  wire logic [COORD_BITS-1:0] ref_x,
  input  wire logic [COORD_BITS-1:0] ref_y,
  output cd_t                        cd
);

  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [PW-1:0] s1x, s1y, s2x, s2y;
  logic [PW-1:0] d1_nxt, d2_nxt, d1_r, d2_r;
  logic [COORD_BITS-1:0] p1x_r, p1y_r, p2x_r, p2y_r, cx_r, cy_r;
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic signed [DW-1:0] px_nxt, py_nxt, qx_nxt, qy_nxt;
  logic signed [DW-1:0] px_r, py_r, qx_r, qy_r;
  logic degen_nxt, degen1_r, degen2_r;
  logic signed [PW-1:0] pxqy_r, pyqx_r, pxqx_r, pyqy_r;
  cd_t cd_nxt, cd_r;

  // Stage 0: squared distances to C
  always_comb begin
    d1x = $signed({1'b0, first_x}) - $signed({1'b0, ref_x});
    d1y = $signed({1'b0, first_y}) - $signed({1'b0, ref_y});
    d2x = $signed({1'b0, second_x}) - $signed({1'b0, ref_x});
    d2y = $signed({1'b0, second_y}) - $signed({1'b0, ref_y});
    s1x = d1x * d1x;
    s1y = d1y * d1y;
    s2x = d2x * d2x;
    s2y = d2y * d2y;
    d1_nxt = $unsigned(s1x) + $unsigned(s1y);
    d2_nxt = $unsigned(s2x) + $unsigned(s2y);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1x_r <= first_x;  p1y_r <= first_y;
      p2x_r <= second_x; p2y_r <= second_y;
      cx_r  <= ref_x;    cy_r  <= ref_y;
      d1_r  <= d1_nxt;   d2_r  <= d2_nxt;
    end
  end

  // Stage 1: strictly closer candidate is B, tie keeps first as vertex A
  always_comb begin
    if (d1_r < d2_r) begin
      bx = p1x_r; by = p1y_r; ax = p2x_r; ay = p2y_r;
    end else begin
      bx = p2x_r; by = p2y_r; ax = p1x_r; ay = p1y_r;
    end
    px_nxt = $signed({1'b0, bx}) - $signed({1'b0, ax});
    py_nxt = $signed({1'b0, by}) - $signed({1'b0, ay});
    qx_nxt = $signed({1'b0, cx_r}) - $signed({1'b0, ax});
    qy_nxt = $signed({1'b0, cy_r}) - $signed({1'b0, ay});
    degen_nxt = ((px_nxt == '0) && (py_nxt == '0)) || ((qx_nxt == '0) && (qy_nxt == '0));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px_r <= px_nxt; py_r <= py_nxt;
      qx_r <= qx_nxt; qy_r <= qy_nxt;
      degen1_r <= degen_nxt;
    end
  end

  // Stage 2: four products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pxqy_r <= px_r * qy_r;
      pyqx_r <= py_r * qx_r;
      pxqx_r <= px_r * qx_r;
      pyqy_r <= py_r * qy_r;
      degen2_r <= degen1_r;
    end
  end

  // Stage 3: cross and dot
  always_comb begin
    cd_nxt.crs   = CDW'(pxqy_r) - CDW'(pyqx_r);
    cd_nxt.dot   = CDW'(pxqx_r) + CDW'(pyqy_r);
    cd_nxt.degen = degen2_r;
  end

  always_ff @(posedge clk) begin
    if (en[3]) cd_r <= cd_nxt;
  end

  assign cd = cd_r;

endmodule
`default_nettype wire

// ===== hdl/iafp_norm.sv =====
// Special cases, quadrant fold and left normalization ahead of CORDIC.
`default_nettype none
module iafp_norm
  import iafp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [NORM_ST-1:0] en,
  input  wire cd_t                cd,
  output lane_t                   lane
);

  logic [CDW-1:0] c_abs, d_neg, xn_nxt, yn_nxt, xn_r, yn_r, orv;
  logic signed [ZW-1:0] z_nxt, z_r;
  logic bypass_nxt, bypass_r, degen_r;
  logic [SHW-1:0] h, s_nxt, s_r;
  lane_t lane_nxt, lane_r;

  // Stage 4: classify, fold obtuse angles, find leading one
  always_comb begin
    c_abs = (cd.crs < 0) ? CDW'(-cd.crs) : CDW'(cd.crs);
    d_neg = CDW'(-cd.dot);
    xn_nxt = CDW'(cd.dot);
    yn_nxt = c_abs;
    z_nxt = '0;
    bypass_nxt = 1'b1;
    if (cd.degen) begin
      z_nxt = '0;
    end else if (c_abs == '0) begin
      z_nxt = (cd.dot > 0) ? '0 : Z_180;
    end else if (cd.dot == '0) begin
      z_nxt = Z_90;
    end else if (cd.dot < 0) begin
      bypass_nxt = 1'b0;
      xn_nxt = c_abs;
      yn_nxt = d_neg;
      z_nxt = Z_90;
    end else begin
      bypass_nxt = 1'b0;
    end
    orv = xn_nxt | yn_nxt;
    h = '0;
    for (int i = 0; i < CDW; i++) begin
      if (orv[i]) h = SHW'(i);
    end
    s_nxt = SHW'(NORM_EXP) - h;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xn_r <= xn_nxt; yn_r <= yn_nxt; z_r <= z_nxt;
      bypass_r <= bypass_nxt; degen_r <= cd.degen; s_r <= s_nxt;
    end
  end

  // Stage 5: shift both magnitudes together
  always_comb begin
    lane_nxt.x = $signed(XW'(xn_r)) <<< s_r;
    lane_nxt.y = $signed(XW'(yn_r)) <<< s_r;
    lane_nxt.z = z_r;
    lane_nxt.bypass = bypass_r;
    lane_nxt.degen = degen_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) lane_r <= lane_nxt;
  end

  assign lane = lane_r;

endmodule
`default_nettype wire

// ===== hdl/iafp_cordic.sv =====
// Vectoring CORDIC, one iteration per pipeline stage, angle accumulated in degrees.
`default_nettype none
module iafp_cordic
  import iafp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic [CORDIC_STEPS-1:0] en,
  input  wire lane_t                   lane_in,
  output lane_t                        lane_out
);

  lane_t st_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    lane_t cur, nxt;
    logic signed [XW-1:0] xs, ys;

    if (i == 0) begin : g_first
      assign cur = lane_in;
    end else begin : g_next
      assign cur = st_r[i-1];
    end

    // Rotate toward the x axis unless the angle is already settled
    always_comb begin
      xs = shr0(cur.x, i);
      ys = shr0(cur.y, i);
      nxt = cur;
      if (!cur.bypass) begin
        if (cur.y >= 0) begin
          nxt.x = cur.x + ys;
          nxt.y = cur.y - xs;
          nxt.z = cur.z + atan_deg(i);
        end else begin
          nxt.x = cur.x - ys;
          nxt.y = cur.y + xs;
          nxt.z = cur.z - atan_deg(i);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) st_r[i] <= nxt;
    end
  end

  assign lane_out = st_r[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/iafp_out.sv =====
// Output stage: clamp, round to the output fraction width, result register.
`default_nettype none
module iafp_out
  import iafp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire lane_t              lane,
  output logic [ANGLE_W-1:0]      angle_deg,
  output logic                    degenerate
);

  localparam int RSH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (RSH - 1);

  logic signed [ZW-1:0] zc, zr;
  logic [ANGLE_W-1:0] ang_nxt, ang_r;
  logic degen_r;

  always_comb begin
    zc = lane.z;
    if (zc < 0) zc = '0;
    if (zc > Z_180) zc = Z_180;
    zr = (zc + HALF) >>> RSH;
    if (zr > ZW'(ANGLE_MAX)) zr = ZW'(ANGLE_MAX);
    ang_nxt = zr[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
      degen_r <= lane.degen;
    end
  end

  assign angle_deg = ang_r;
  assign degenerate = degen_r;

endmodule
`default_nettype wire

// ===== hdl/iafp_checker.sv =====
// Port-level checker for the far-point angle block, bound to the top level.
`default_nettype none
module iafp_checker
  import iafp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [ANGLE_W-1:0] out_angle_deg,
  input wire logic               out_degenerate
);

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle_deg) && $stable(out_degenerate))
    else $error("result beat changed under stall");

  // Degenerate beats carry a zero angle
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_angle_deg == '0)
    else $error("degenerate beat with nonzero angle");

  // Angle never exceeds 180 degrees
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_deg <= ANGLE_W'(ANGLE_MAX))
    else $error("angle above 180 degrees");

  // A draining output frees the input side
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // Pipeline empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind inner_angle_at_far_point_top iafp_checker u_iafp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_angle_deg  (out_angle_deg),
  .out_degenerate (out_degenerate)
);
`default_nettype wire
